>>> hdl/audio_mixer_gain_ramp_top_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the audio mixer with gain ramp.
// Each macro reports through $error and is disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef AUDIO_MIXER_GAIN_RAMP_TOP_DEFINES_SVH
`define AUDIO_MIXER_GAIN_RAMP_TOP_DEFINES_SVH

// Same-cycle implication, sampled on the rising edge of clock.
`define AMGR_ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising edge of clock.
`define AMGR_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hdl/amgr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amgr_pkg
// Shared types, constants and arithmetic helpers of the gain ramp mixer.
// ----------------------------------------------------------------------------
package amgr_pkg;

   localparam int CHANNELS_DEFAULT = 4;
   localparam int PACKED_CHANNELS  = 4;
   localparam int SAMPLE_W         = 16;
   localparam int GAIN_W           = 32;
   localparam int MANT_W           = 8;
   localparam int EXP_W            = 4;
   localparam int SHAMT_W          = 5;
   localparam int CSR_INDEX_W      = 3;
   localparam int CSR_DATA_W       = 32;
   localparam int GAIN_FRAC_SHIFT  = 23;
   localparam int RAMP_SHIFT_BASE  = 16;
   localparam int BASE_SHIFT       = 9;
   localparam int OUT_MANT_SHIFT   = 7;

   localparam logic [31:0] GAIN_MANT_RESET = 32'h0000_0000;
   localparam logic [15:0] GAIN_EXP_RESET  = 16'h5555;
   localparam logic [3:0]  ENABLE_RESET    = 4'hF;
   localparam logic [3:0]  SLOPE_RESET     = 4'd4;
   localparam logic [7:0]  OUT_MANT_RESET  = 8'd128;
   localparam logic [3:0]  OUT_EXP_RESET   = 4'd5;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_GAIN_MANTISSAS  = 3'd0,
      CSR_GAIN_EXPONENTS  = 3'd1,
      CSR_CHANNEL_ENABLE  = 3'd2,
      CSR_RAMP_SLOPE      = 3'd3,
      CSR_OUT_GAIN_MANT   = 3'd4,
      CSR_OUT_GAIN_EXP    = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [31:0] gain_mantissas;
      logic [15:0] gain_exponents;
      logic [3:0]  channel_enable_mask;
      logic [3:0]  ramp_slope;
      logic [7:0]  out_gain_mantissa;
      logic [3:0]  out_gain_exponent;
   } amgr_cfg_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_SCALE,
      ST_DONE
   } amgr_state_type;

   // Clamp a wide signed value to the 16-bit sample range.
   function automatic logic signed [SAMPLE_W-1:0] sat16(input logic signed [32:0] v);
      logic signed [32:0] hi;
      logic signed [32:0] lo;
      hi = 33'sd32767;
      lo = -33'sd32768;
      if (v > hi) begin
         return 16'sh7FFF;
      end else if (v < lo) begin
         return -16'sh8000;
      end
      return v[SAMPLE_W-1:0];
   endfunction

   // Post-multiply shift amount: base shift plus a 4-bit exponent.
   function automatic logic [SHAMT_W-1:0] mul_shift(input logic [EXP_W-1:0] ex);
      return SHAMT_W'(BASE_SHIFT) + SHAMT_W'(ex);
   endfunction

endpackage

>>> hdl/amgr_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amgr_req_if / amgr_rsp_if
// Valid/ready channels carrying sample vectors in and mixed samples out.
// ----------------------------------------------------------------------------
interface amgr_req_if import amgr_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] sample_ch0;
   logic signed [SAMPLE_W-1:0] sample_ch1;
   logic signed [SAMPLE_W-1:0] sample_ch2;
   logic signed [SAMPLE_W-1:0] sample_ch3;

   modport source (output valid, sample_ch0, sample_ch1, sample_ch2, sample_ch3,
                   input ready);
   modport sink (input valid, sample_ch0, sample_ch1, sample_ch2, sample_ch3,
                 output ready);
endinterface

interface amgr_rsp_if import amgr_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] mixed_sample;

   modport source (output valid, mixed_sample, input ready);
   modport sink (input valid, mixed_sample, output ready);
endinterface

>>> hdl/amgr_csr.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amgr_csr
// Configuration registers, written through a plain index/data write port.
// ----------------------------------------------------------------------------
module amgr_csr import amgr_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output amgr_cfg_type           cfg
);

   amgr_cfg_type cfg_ff;
   amgr_cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_GAIN_MANTISSAS: cfg_in.gain_mantissas      = csr_wdata[31:0];
            CSR_GAIN_EXPONENTS: cfg_in.gain_exponents      = csr_wdata[15:0];
            CSR_CHANNEL_ENABLE: cfg_in.channel_enable_mask = csr_wdata[3:0];
            CSR_RAMP_SLOPE:     cfg_in.ramp_slope          = csr_wdata[3:0];
            CSR_OUT_GAIN_MANT:  cfg_in.out_gain_mantissa   = csr_wdata[7:0];
            CSR_OUT_GAIN_EXP:   cfg_in.out_gain_exponent   = csr_wdata[3:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain_mantissas      <= GAIN_MANT_RESET;
         cfg_ff.gain_exponents      <= GAIN_EXP_RESET;
         cfg_ff.channel_enable_mask <= ENABLE_RESET;
         cfg_ff.ramp_slope          <= SLOPE_RESET;
         cfg_ff.out_gain_mantissa   <= OUT_MANT_RESET;
         cfg_ff.out_gain_exponent   <= OUT_EXP_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> hdl/amgr_gain_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amgr_gain_mem
// Per-channel gain store: one write and one registered read per cycle.
// Entries never written since reset read as zero through their valid bits.
// ----------------------------------------------------------------------------
module amgr_gain_mem import amgr_pkg::*; #(
   parameter int DEPTH = CHANNELS_DEFAULT,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              rd_en,
   input  logic [AW-1:0]     rd_addr,
   output logic [GAIN_W-1:0] rd_data,
   input  logic              wr_en,
   input  logic [AW-1:0]     wr_addr,
   input  logic [GAIN_W-1:0] wr_data
);

   logic [GAIN_W-1:0] mem [DEPTH];
   logic [DEPTH-1:0]  valid_ff;
   logic [GAIN_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= valid_ff[rd_addr] ? mem[rd_addr] : '0;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/amgr_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amgr_core
// Mixing sequencer: walks the channels one per cycle against the gain store,
// accumulates with saturation, steps each gain, then applies output gain.
// ----------------------------------------------------------------------------
module amgr_core import amgr_pkg::*; #(
   parameter int CHANNELS = CHANNELS_DEFAULT,
   localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
   input  logic              clock,
   input  logic              reset,
   input  amgr_cfg_type      cfg,
   amgr_req_if.sink          req_ch,
   amgr_rsp_if.source        rsp_ch,
   output logic              mem_rd_en,
   output logic [AW-1:0]     mem_rd_addr,
   input  logic [GAIN_W-1:0] mem_rd_data,
   output logic              mem_wr_en,
   output logic [AW-1:0]     mem_wr_addr,
   output logic [GAIN_W-1:0] mem_wr_data
);

   amgr_state_type             state_ff, state_in;
   logic [AW-1:0]              ch_ff, ch_in;
   logic signed [SAMPLE_W-1:0] sum_ff, sum_in;
   logic signed [31:0]         prod_ff, prod_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_W-1:0] rsp_data_ff, rsp_data_in;
   logic signed [SAMPLE_W-1:0] samples_ff [PACKED_CHANNELS];
   logic signed [SAMPLE_W-1:0] samples_in [PACKED_CHANNELS];

   logic                       accept;
   logic [2:0]                 ch_sel;
   logic [MANT_W-1:0]          mant;
   logic [EXP_W-1:0]           ex;
   logic                       en;
   logic signed [GAIN_W-1:0]   cur;
   logic signed [15:0]         gain_hi;
   logic signed [31:0]         mix_prod;
   logic signed [31:0]         term;
   logic signed [32:0]         acc;
   logic signed [32:0]         target;
   logic signed [32:0]         diff;
   logic [SHAMT_W-1:0]         ramp_shift;
   logic signed [32:0]         step;
   logic signed [32:0]         upd;
   logic signed [15:0]         out_gain;
   logic signed [31:0]         scaled;

   assign accept = req_ch.valid && req_ch.ready;

   // Channel field selection; channels past the packed four read a zero mantissa.
   assign ch_sel = 3'(ch_ff);
   assign mant   = ch_sel[2] ? '0 : cfg.gain_mantissas[ch_sel[1:0]*MANT_W +: MANT_W];
   assign ex     = cfg.gain_exponents[ch_sel[1:0]*EXP_W +: EXP_W];
   assign en     = cfg.channel_enable_mask[ch_sel[1:0]];

   // Channel term and saturating accumulation.
   assign cur      = signed'(mem_rd_data);
   assign gain_hi  = signed'(mem_rd_data[GAIN_W-1:16]);
   assign mix_prod = 32'(samples_ff[ch_sel[1:0]]) * 32'(gain_hi);
   assign term     = mix_prod >>> mul_shift(ex);
   assign acc      = 33'(sum_ff) + 33'(term);

   // First-order gain step toward the target.
   assign target     = en ? {2'b00, mant, {GAIN_FRAC_SHIFT{1'b0}}} : '0;
   assign diff       = target - 33'(cur);
   assign ramp_shift = en ? SHAMT_W'(RAMP_SHIFT_BASE) - SHAMT_W'(cfg.ramp_slope)
                          : SHAMT_W'(RAMP_SHIFT_BASE) - SHAMT_W'(cfg.ramp_slope >> 1);
   assign step       = diff >>> ramp_shift;
   assign upd        = 33'(cur) + step;

   // Output gain.
   assign out_gain = signed'({1'b0, cfg.out_gain_mantissa, {OUT_MANT_SHIFT{1'b0}}});
   assign scaled   = prod_ff >>> mul_shift(cfg.out_gain_exponent);

   always_comb begin
      samples_in[0] = accept ? req_ch.sample_ch0 : samples_ff[0];
      samples_in[1] = accept ? req_ch.sample_ch1 : samples_ff[1];
      samples_in[2] = accept ? req_ch.sample_ch2 : samples_ff[2];
      samples_in[3] = accept ? req_ch.sample_ch3 : samples_ff[3];
   end

   always_comb begin
      state_in     = state_ff;
      ch_in        = ch_ff;
      sum_in       = sum_ff;
      prod_in      = prod_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_data_in  = rsp_data_ff;
      mem_rd_en    = 1'b0;
      mem_rd_addr  = ch_ff;
      mem_wr_en    = 1'b0;
      mem_wr_addr  = ch_ff;
      mem_wr_data  = upd[GAIN_W-1:0];
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = '0;
               ch_in       = '0;
               sum_in      = '0;
               state_in    = ST_RUN;
            end
         end
         ST_RUN: begin
            if (mant == '0) begin
               state_in = ST_SCALE;
            end else begin
               sum_in    = sat16(acc);
               mem_wr_en = 1'b1;
               if (ch_ff == AW'(CHANNELS - 1)) begin
                  state_in = ST_SCALE;
               end else begin
                  mem_rd_en   = 1'b1;
                  mem_rd_addr = ch_ff + AW'(1);
                  ch_in       = ch_ff + AW'(1);
               end
            end
         end
         ST_SCALE: begin
            prod_in  = 32'(sum_ff) * 32'(out_gain);
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = sat16(33'(scaled));
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ch_ff       <= ch_in;
      sum_ff      <= sum_in;
      prod_ff     <= prod_in;
      rsp_data_ff <= rsp_data_in;
      samples_ff  <= samples_in;
   end

   assign req_ch.ready        = (state_ff == ST_IDLE);
   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.mixed_sample = rsp_data_ff;

endmodule

>>> hdl/audio_mixer_gain_ramp_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// audio_mixer_gain_ramp_top
// Mixer with per-channel first-order gain ramps and a saturating output gain.
// ----------------------------------------------------------------------------
// Usage:
// The req_ch channel carries one transaction per sample vector, one signed
// 16-bit sample per input channel. The rsp_ch channel returns one transaction
// holding the mixed, output-scaled and saturated sample. Both use valid/ready.
// Channels are mixed in order until the first one whose gain mantissa is zero.
// Each mixed channel's gain lives in a small gain memory; one channel is read,
// accumulated and written back per cycle, with the next channel's read issued
// in the same cycle. When the walk stops before the last channel, a further
// step sees the zero mantissa, so the walk takes that step even when no
// channel is mixed. The sum is then multiplied by the output gain in
// ST_SCALE, and the shifted, saturated result is registered in ST_DONE. A
// new request is taken only once the sequencer is back in ST_IDLE, so not
// before the previous one has finished its walk and output scaling.
// The response register holds a finished result while the receiver stalls;
// the next request is still taken and processed, and waits for the register
// to drain only at its final step. Reset clears the sequencer, restores the
// configuration defaults and returns every channel gain to zero.
// Configuration is written through csr_wr_en/csr_index/csr_wdata while idle.
// ----------------------------------------------------------------------------
`include "audio_mixer_gain_ramp_top_defines.svh"

module audio_mixer_gain_ramp_top import amgr_pkg::*; #(
   parameter int CHANNELS = CHANNELS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   amgr_req_if.sink               req_ch,
   amgr_rsp_if.source             rsp_ch
);

   localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   amgr_cfg_type      cfg;
   logic              mem_rd_en;
   logic [AW-1:0]     mem_rd_addr;
   logic [GAIN_W-1:0] mem_rd_data;
   logic              mem_wr_en;
   logic [AW-1:0]     mem_wr_addr;
   logic [GAIN_W-1:0] mem_wr_data;

   // Configuration registers.
   amgr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // Channel gain store, zero after reset.
   amgr_gain_mem #(
      .DEPTH (CHANNELS)
   ) u_gain_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data)
   );

   // Channel walk, accumulation, gain stepping and output scaling.
   amgr_core #(
      .CHANNELS (CHANNELS)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data)
   );

   // The walk never reads the entry it is writing back in the same cycle.
   `AMGR_ASSERT_IMPLIES(a_no_rw_collision, mem_rd_en && mem_wr_en,
                        mem_rd_addr != mem_wr_addr,
                        "gain memory read and write hit the same entry")
   // Gains are written back only while a transaction is in flight.
   `AMGR_ASSERT_IMPLIES(a_write_only_busy, mem_wr_en, !req_ch.ready,
                        "gain write-back while the mixer is idle")
   // A request transaction starts the walk, so no second one is taken next cycle.
   `AMGR_ASSERT_NEXT(a_busy_after_accept, req_ch.valid && req_ch.ready, !req_ch.ready,
                     "request taken while the previous one is still mixing")

endmodule
